@@ hdl/gda_pkg.sv @@
`default_nettype none

package gda_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = 12;
    localparam int DOY_W   = 9;
    localparam int WD_W    = 3;
    localparam int DW_W    = 14;
    localparam int Q100_W  = 6;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam int DEF_BASE_YEAR  = 1900;
    localparam int DEF_YEAR_SPAN  = 256;
    localparam int DEF_COUNT_BITS = 12;

    // reciprocal of 100 for 12-bit years
    localparam int RECIP100       = 1311;
    localparam int RECIP100_SHIFT = 17;

    // weekday offset: 1 Jan 1600 was a Saturday
    localparam int LEAPS_1599 = 1599 / 4 - 1599 / 100 + 1599 / 400;
    localparam int WD_BIAS    = ((5 - 1600 - LEAPS_1599) % 7 + 7) % 7;

    typedef logic [MONTH_W-1:0]       month_t;
    typedef logic [DAY_W-1:0]         day_t;
    typedef logic [YEAR_W-1:0]        year_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [DOY_W-1:0]         doy_t;
    typedef logic [WD_W-1:0]          wd_t;
    typedef logic [Q100_W-1:0]        q100_t;
    typedef logic signed [DW_W-1:0]   dw_t;

    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_NEXT  = 2'd2,
        OP_QUERY = 2'd3
    } gda_op_t;

    typedef struct packed {
        q100_t q100;
        logic  leap;
    } gda_yinfo_t;

    typedef struct packed {
        month_t month;
        day_t   day;
        year_t  year;
        doy_t   doy;
        wd_t    weekday;
        logic   leap;
        logic   error;
    } gda_result_t;

    function automatic day_t month_len(input month_t m, input logic leap);
        day_t l;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
            4'd2:                                      l = leap ? 5'd29 : 5'd28;
            default:                                   l = 5'd0;
        endcase
        return l;
    endfunction

    function automatic doy_t days_before(input month_t m);
        doy_t d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hdl/gda_year_unit.sv @@
`default_nettype none

// year / 100 by reciprocal multiply, plus Gregorian leap flag
module gda_year_unit (
    input  wire gda_pkg::year_t     year,
    output gda_pkg::gda_yinfo_t     info
);

    localparam int PROD_W = gda_pkg::YEAR_W + 11;

    logic [PROD_W-1:0]    prod;
    gda_pkg::q100_t       q;
    gda_pkg::year_t       hundred;
    logic                 mult100;

    always_comb
    begin
        prod    = {{(PROD_W-gda_pkg::YEAR_W){1'b0}}, year} * PROD_W'(gda_pkg::RECIP100);
        q       = prod[gda_pkg::RECIP100_SHIFT +: gda_pkg::Q100_W];
        hundred = {q, 6'b0} + {1'b0, q, 5'b0} + {4'b0, q, 2'b0};
        mult100 = (hundred == year);
        info.q100 = q;
        info.leap = (year[1:0] == 2'b00) && (!mult100 || (q[1:0] == 2'b00));
    end

endmodule

`default_nettype wire

@@ hdl/gda_core.sv @@
`default_nettype none

module gda_core #(
    parameter int BASE_YEAR  = gda_pkg::DEF_BASE_YEAR,
    parameter int YEAR_SPAN  = gda_pkg::DEF_YEAR_SPAN,
    parameter int COUNT_BITS = gda_pkg::DEF_COUNT_BITS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire gda_pkg::gda_op_t        op,
    input  wire gda_pkg::month_t         in_month,
    input  wire gda_pkg::day_t           in_day,
    input  wire gda_pkg::year_t          in_year,
    input  wire gda_pkg::count_t         day_count,
    output logic                         in_ready,
    output logic                         res_valid,
    input  wire                          res_ready,
    output gda_pkg::gda_result_t         result
);

    localparam gda_pkg::year_t FIRST_YEAR = gda_pkg::year_t'(BASE_YEAR);
    localparam gda_pkg::year_t LAST_YEAR  = gda_pkg::year_t'(BASE_YEAR + YEAR_SPAN - 1);
    localparam int CNT_USED = (COUNT_BITS < gda_pkg::COUNT_W) ? COUNT_BITS : gda_pkg::COUNT_W;
    localparam gda_pkg::count_t CNT_MASK = gda_pkg::count_t'((64'd1 << CNT_USED) - 64'd1);
    localparam int DPAD = gda_pkg::DW_W - gda_pkg::DAY_W;
    localparam int CPAD = gda_pkg::DW_W - gda_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEAP,
        S_CHECK,
        S_WALK,
        S_YEAR,
        S_QUOT,
        S_SUM,
        S_MOD,
        S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    gda_pkg::gda_op_t        op_reg, op_next;
    gda_pkg::month_t         in_m_reg, in_m_next;
    gda_pkg::day_t           in_d_reg, in_d_next;
    gda_pkg::year_t          in_y_reg, in_y_next;
    gda_pkg::count_t         cnt_reg, cnt_next;
    gda_pkg::month_t         m_reg, m_next;
    gda_pkg::year_t          y_reg, y_next;
    gda_pkg::dw_t            dw_reg, dw_next;
    logic                    leap_reg, leap_next;
    logic                    in_leap_reg, in_leap_next;
    logic                    err_reg, err_next;
    gda_pkg::q100_t          q_reg, q_next;
    logic [12:0]             s_reg, s_next;
    gda_pkg::doy_t           doy_reg, doy_next;
    gda_pkg::gda_result_t    res_reg, res_next;

    gda_pkg::year_t          yu_year;
    gda_pkg::gda_yinfo_t     yu;

    gda_pkg::day_t           len_cur;
    gda_pkg::day_t           len_prev;
    gda_pkg::dw_t            len_cur_ext;
    gda_pkg::dw_t            in_d_ext;
    gda_pkg::dw_t            cnt_ext;
    logic                    date_ok;
    gda_pkg::year_t          ym1;
    gda_pkg::year_t          lcount;
    logic [4:0]              oct_sum;
    logic [3:0]              oct_fold;
    gda_pkg::wd_t            wd;

    gda_year_unit u_year (
        .year (yu_year),
        .info (yu)
    );

    assign yu_year   = (state_reg == S_QUOT) ? (y_reg - 12'd1) : y_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign result    = res_reg;

    always_comb
    begin
        len_cur     = gda_pkg::month_len(m_reg, leap_reg);
        len_prev    = gda_pkg::month_len(m_reg - 4'd1, leap_reg);
        len_cur_ext = gda_pkg::dw_t'({{DPAD{1'b0}}, len_cur});
        in_d_ext    = gda_pkg::dw_t'({{DPAD{1'b0}}, in_d_reg});
        cnt_ext     = gda_pkg::dw_t'({{CPAD{1'b0}}, cnt_reg});
        date_ok     = (in_m_reg != 4'd0) && (in_m_reg <= gda_pkg::MONTH_DEC)
                   && (in_y_reg >= FIRST_YEAR) && (in_y_reg <= LAST_YEAR)
                   && (in_d_reg != 5'd0)
                   && (in_d_reg <= gda_pkg::month_len(in_m_reg, leap_reg));
        ym1         = y_reg - 12'd1;
        lcount      = {2'b0, ym1[11:2]} - {6'b0, q_reg} + {8'b0, q_reg[5:2]};
        // mod 7 by folding octal digits
        oct_sum     = {2'b0, s_reg[2:0]} + {2'b0, s_reg[5:3]} + {2'b0, s_reg[8:6]}
                    + {2'b0, s_reg[11:9]} + {4'b0, s_reg[12]};
        oct_fold    = {1'b0, oct_sum[2:0]} + {2'b0, oct_sum[4:3]};
        wd          = (oct_fold >= 4'd7) ? 3'(oct_fold - 4'd7) : oct_fold[2:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        in_m_next    = in_m_reg;
        in_d_next    = in_d_reg;
        in_y_next    = in_y_reg;
        cnt_next     = cnt_reg;
        m_next       = m_reg;
        y_next       = y_reg;
        dw_next      = dw_reg;
        leap_next    = leap_reg;
        in_leap_next = in_leap_reg;
        err_next     = err_reg;
        q_next       = q_reg;
        s_next       = s_reg;
        doy_next     = doy_reg;
        res_next     = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    in_m_next  = in_month;
                    in_d_next  = in_day;
                    in_y_next  = in_year;
                    cnt_next   = day_count & CNT_MASK;
                    m_next     = in_month;
                    y_next     = in_year;
                    err_next   = 1'b0;
                    state_next = S_LEAP;
                end
            end
            S_LEAP:
            begin
                leap_next  = yu.leap;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                in_leap_next = leap_reg;
                dw_next      = in_d_ext;
                if (!date_ok)
                begin
                    res_next.month   = in_m_reg;
                    res_next.day     = in_d_reg;
                    res_next.year    = in_y_reg;
                    res_next.doy     = '0;
                    res_next.weekday = '0;
                    res_next.leap    = 1'b0;
                    res_next.error   = 1'b1;
                    state_next       = S_OUT;
                end
                else if (op_reg == gda_pkg::OP_QUERY)
                begin
                    state_next = S_QUOT;
                end
                else if (op_reg == gda_pkg::OP_SUB)
                begin
                    dw_next    = in_d_ext - cnt_ext;
                    state_next = S_WALK;
                end
                else if (op_reg == gda_pkg::OP_NEXT)
                begin
                    dw_next    = in_d_ext + gda_pkg::dw_t'(1);
                    state_next = S_WALK;
                end
                else
                begin
                    dw_next    = in_d_ext + cnt_ext;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (op_reg == gda_pkg::OP_SUB)
                begin
                    if (dw_reg < gda_pkg::dw_t'(1))
                    begin
                        if (m_reg == gda_pkg::MONTH_JAN)
                        begin
                            if (y_reg == FIRST_YEAR)
                            begin
                                m_next     = in_m_reg;
                                y_next     = in_y_reg;
                                dw_next    = in_d_ext;
                                leap_next  = in_leap_reg;
                                err_next   = 1'b1;
                                state_next = S_QUOT;
                            end
                            else
                            begin
                                m_next     = gda_pkg::MONTH_DEC;
                                y_next     = y_reg - 12'd1;
                                dw_next    = dw_reg + gda_pkg::dw_t'({{DPAD{1'b0}},
                                             gda_pkg::month_len(gda_pkg::MONTH_DEC, 1'b0)});
                                state_next = S_YEAR;
                            end
                        end
                        else
                        begin
                            m_next  = m_reg - 4'd1;
                            dw_next = dw_reg + gda_pkg::dw_t'({{DPAD{1'b0}}, len_prev});
                        end
                    end
                    else
                    begin
                        state_next = S_QUOT;
                    end
                end
                else
                begin
                    if (dw_reg > len_cur_ext)
                    begin
                        if (m_reg == gda_pkg::MONTH_DEC)
                        begin
                            if (y_reg == LAST_YEAR)
                            begin
                                m_next     = in_m_reg;
                                y_next     = in_y_reg;
                                dw_next    = in_d_ext;
                                leap_next  = in_leap_reg;
                                err_next   = 1'b1;
                                state_next = S_QUOT;
                            end
                            else
                            begin
                                m_next     = gda_pkg::MONTH_JAN;
                                y_next     = y_reg + 12'd1;
                                dw_next    = dw_reg - len_cur_ext;
                                state_next = S_YEAR;
                            end
                        end
                        else
                        begin
                            m_next  = m_reg + 4'd1;
                            dw_next = dw_reg - len_cur_ext;
                        end
                    end
                    else
                    begin
                        state_next = S_QUOT;
                    end
                end
            end
            S_YEAR:
            begin
                leap_next  = yu.leap;
                state_next = S_WALK;
            end
            S_QUOT:
            begin
                q_next     = yu.q100;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                doy_next   = gda_pkg::days_before(m_reg) + {4'b0, dw_reg[4:0]}
                           + {8'b0, (m_reg > gda_pkg::MONTH_FEB) && leap_reg};
                s_next     = {1'b0, y_reg} + {1'b0, lcount}
                           + {4'b0, gda_pkg::days_before(m_reg) + {4'b0, dw_reg[4:0]}
                           + {8'b0, (m_reg > gda_pkg::MONTH_FEB) && leap_reg}}
                           + 13'(gda_pkg::WD_BIAS);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                res_next.month   = m_reg;
                res_next.day     = dw_reg[4:0];
                res_next.year    = y_reg;
                res_next.doy     = doy_reg;
                res_next.weekday = wd;
                res_next.leap    = leap_reg;
                res_next.error   = err_reg;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= gda_pkg::OP_QUERY;
            in_m_reg    <= '0;
            in_d_reg    <= '0;
            in_y_reg    <= '0;
            cnt_reg     <= '0;
            m_reg       <= '0;
            y_reg       <= '0;
            dw_reg      <= '0;
            leap_reg    <= 1'b0;
            in_leap_reg <= 1'b0;
            err_reg     <= 1'b0;
            q_reg       <= '0;
            s_reg       <= '0;
            doy_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            in_m_reg    <= in_m_next;
            in_d_reg    <= in_d_next;
            in_y_reg    <= in_y_next;
            cnt_reg     <= cnt_next;
            m_reg       <= m_next;
            y_reg       <= y_next;
            dw_reg      <= dw_next;
            leap_reg    <= leap_next;
            in_leap_reg <= in_leap_next;
            err_reg     <= err_next;
            q_reg       <= q_next;
            s_reg       <= s_next;
            doy_reg     <= doy_next;
            res_reg     <= res_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gregorian_date_arithmetic_core.sv @@
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: date and day count, tuser: op
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: result date info, tuser: error
//
// Each item gets a leap lookup and a date check; a shift then walks a month per step,
// with a year step per year crossed; then the /100 quotient, sum, mod and output.
// A bad date skips to output. No new item is taken before the result leaves the core.
// All leap and /100 work shares one reciprocal-multiply year unit.
// rst_n is asynchronous and clears all state; the block comes up idle.
// One result waits in the output register; a new item is taken meanwhile, and the
// sequencer holds its next result until that register frees up.
module gregorian_date_arithmetic_core #(
    parameter int BASE_YEAR  = gda_pkg::DEF_BASE_YEAR,
    parameter int YEAR_SPAN  = gda_pkg::DEF_YEAR_SPAN,
    parameter int COUNT_BITS = gda_pkg::DEF_COUNT_BITS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // in_month, in_day, in_year, day_count, zero pad
    input  wire [gda_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op
    input  wire [1:0]                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // out_month, out_day, out_year, day_of_year, weekday, leap, zero pad
    output logic [gda_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // error
    output logic [0:0]                         m_axis_tuser
);

    logic                    core_ready;
    logic                    res_valid;
    logic                    res_ready;
    gda_pkg::gda_result_t    res;
    logic                    out_valid_reg, out_valid_next;
    gda_pkg::gda_result_t    out_reg, out_next;

    gda_core #(
        .BASE_YEAR  (BASE_YEAR),
        .YEAR_SPAN  (YEAR_SPAN),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid),
        .op        (gda_pkg::gda_op_t'(s_axis_tuser)),
        .in_month  (s_axis_tdata[3:0]),
        .in_day    (s_axis_tdata[8:4]),
        .in_year   (s_axis_tdata[20:9]),
        .day_count (s_axis_tdata[32:21]),
        .in_ready  (core_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (res)
    );

    assign s_axis_tready = core_ready;
    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.error;
    assign m_axis_tdata  = {6'b0, out_reg.leap, out_reg.weekday, out_reg.doy,
                            out_reg.year, out_reg.day, out_reg.month};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ verif/gregorian_date_arithmetic_core_test.sv @@
`timescale 1ns / 100ps

module gregorian_date_arithmetic_core_test;

    localparam int FIRST_YEAR  = gda_pkg::DEF_BASE_YEAR;
    localparam int FINAL_YEAR  = gda_pkg::DEF_BASE_YEAR + gda_pkg::DEF_YEAR_SPAN - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 130;

    typedef struct packed {
        gda_pkg::gda_op_t     op;
        gda_pkg::month_t      month;
        gda_pkg::day_t        day;
        gda_pkg::year_t       year;
        gda_pkg::count_t      count;
        logic                 typed;
        gda_pkg::gda_result_t want;
    } date_case_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [gda_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [gda_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                      m_axis_tuser;

    gda_pkg::gda_result_t pending_dates[$];
    int                   mismatches = 0;
    int                   cycles = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;

    // directed items; typed rows carry their result, the rest go to the predictor
    date_case_t directed_dates[25] = '{
        '{gda_pkg::OP_QUERY, 4'd1,  5'd1,  12'd1900, 12'd0,    1'b1,
          '{4'd1, 5'd1, 12'd1900, 9'd1, 3'd1, 1'b0, 1'b0}},
        '{gda_pkg::OP_ADD,   4'd1,  5'd1,  12'd1900, 12'd0,    1'b1,
          '{4'd1, 5'd1, 12'd1900, 9'd1, 3'd1, 1'b0, 1'b0}},
        '{gda_pkg::OP_SUB,   4'd1,  5'd1,  12'd1900, 12'd1,    1'b1,
          '{4'd1, 5'd1, 12'd1900, 9'd1, 3'd1, 1'b0, 1'b1}},
        '{gda_pkg::OP_QUERY, 4'd12, 5'd31, 12'd2155, 12'd4095, 1'b0, '0},
        '{gda_pkg::OP_ADD,   4'd1,  5'd1,  12'd1900, 12'd4095, 1'b0, '0},
        '{gda_pkg::OP_SUB,   4'd12, 5'd31, 12'd2155, 12'd4095, 1'b0, '0},
        '{gda_pkg::OP_NEXT,  4'd12, 5'd31, 12'd2155, 12'd4095, 1'b0, '0},
        '{gda_pkg::OP_ADD,   4'd12, 5'd31, 12'd2150, 12'd4095, 1'b0, '0},
        '{gda_pkg::OP_SUB,   4'd1,  5'd1,  12'd1905, 12'd4095, 1'b0, '0},
        '{gda_pkg::OP_NEXT,  4'd2,  5'd28, 12'd2000, 12'd0,    1'b0, '0},
        '{gda_pkg::OP_NEXT,  4'd2,  5'd28, 12'd1900, 12'd0,    1'b0, '0},
        '{gda_pkg::OP_NEXT,  4'd2,  5'd29, 12'd2000, 12'd0,    1'b0, '0},
        '{gda_pkg::OP_NEXT,  4'd12, 5'd31, 12'd1999, 12'd0,    1'b0, '0},
        '{gda_pkg::OP_SUB,   4'd3,  5'd1,  12'd2004, 12'd1,    1'b0, '0},
        '{gda_pkg::OP_ADD,   4'd1,  5'd1,  12'd2100, 12'd365,  1'b0, '0},
        '{gda_pkg::OP_QUERY, 4'd2,  5'd29, 12'd2000, 12'd0,    1'b0, '0},
        '{gda_pkg::OP_QUERY, 4'd2,  5'd29, 12'd1900, 12'd0,    1'b1,
          '{4'd2, 5'd29, 12'd1900, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_QUERY, 4'd0,  5'd1,  12'd2000, 12'd0,    1'b1,
          '{4'd0, 5'd1, 12'd2000, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_QUERY, 4'd13, 5'd1,  12'd2000, 12'd0,    1'b1,
          '{4'd13, 5'd1, 12'd2000, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_ADD,   4'd15, 5'd31, 12'd4095, 12'd4095, 1'b1,
          '{4'd15, 5'd31, 12'd4095, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_QUERY, 4'd4,  5'd31, 12'd2000, 12'd0,    1'b1,
          '{4'd4, 5'd31, 12'd2000, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_QUERY, 4'd1,  5'd0,  12'd2000, 12'd0,    1'b1,
          '{4'd1, 5'd0, 12'd2000, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_QUERY, 4'd1,  5'd1,  12'd1899, 12'd0,    1'b1,
          '{4'd1, 5'd1, 12'd1899, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_NEXT,  4'd1,  5'd1,  12'd2156, 12'd0,    1'b1,
          '{4'd1, 5'd1, 12'd2156, 9'd0, 3'd0, 1'b0, 1'b1}},
        '{gda_pkg::OP_SUB,   4'd6,  5'd15, 12'd2024, 12'd0,    1'b0, '0}
    };

    gregorian_date_arithmetic_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit year_is_leap(int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int leap_years_to(int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // days from 1 Jan 1600 to the end of the year before y
    function automatic int days_to_year(int y);
        return 365 * (y - 1600) + leap_years_to(y - 1) - leap_years_to(1599);
    endfunction

    function automatic int days_in_month(int m, int y);
        case (m)
            2:             return year_is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic int day_in_year(int m, int d, int y);
        int total;
        total = d;
        for (int k = 1; k < m; k++)
            total += days_in_month(k, y);
        return total;
    endfunction

    function automatic gda_pkg::gda_result_t date_info(int m, int d, int y, bit err);
        gda_pkg::gda_result_t r;
        int                   doy;
        doy       = day_in_year(m, d, y);
        r.month   = gda_pkg::month_t'(m);
        r.day     = gda_pkg::day_t'(d);
        r.year    = gda_pkg::year_t'(y);
        r.doy     = gda_pkg::doy_t'(doy);
        // 1 Jan 1600 was a Saturday
        r.weekday = gda_pkg::wd_t'((days_to_year(y) + doy + 5) % 7);
        r.leap    = year_is_leap(y);
        r.error   = err;
        return r;
    endfunction

    function automatic gda_pkg::gda_result_t shifted_date(gda_pkg::gda_op_t op,
                                                          gda_pkg::month_t month,
                                                          gda_pkg::day_t day,
                                                          gda_pkg::year_t year,
                                                          gda_pkg::count_t count);
        gda_pkg::gda_result_t r;
        int                   m, d, y, n, start, target, ry, rm, rd;
        m = int'(month);
        d = int'(day);
        y = int'(year);
        if (m < 1 || m > 12 || y < FIRST_YEAR || y > FINAL_YEAR ||
            d < 1 || d > days_in_month(m, y))
        begin
            r       = '0;
            r.month = month;
            r.day   = day;
            r.year  = year;
            r.error = 1'b1;
            return r;
        end
        if (op == gda_pkg::OP_QUERY)
            return date_info(m, d, y, 1'b0);
        n = (op == gda_pkg::OP_NEXT) ? 1 : int'(count);
        start = days_to_year(y) + day_in_year(m, d, y);
        if (op == gda_pkg::OP_SUB)
        begin
            if (start < days_to_year(FIRST_YEAR) + 1 + n)
                return date_info(m, d, y, 1'b1);
            target = start - n;
        end
        else
        begin
            target = start + n;
            if (target > days_to_year(FINAL_YEAR + 1))
                return date_info(m, d, y, 1'b1);
        end
        ry = FIRST_YEAR;
        while (ry < FINAL_YEAR && days_to_year(ry + 1) < target)
            ry++;
        rd = target - days_to_year(ry);
        rm = 1;
        while (rm < 12 && rd > days_in_month(rm, ry))
        begin
            rd -= days_in_month(rm, ry);
            rm++;
        end
        return date_info(rm, rd, ry, 1'b0);
    endfunction

    task automatic send_date(gda_pkg::gda_op_t op, gda_pkg::month_t month,
                             gda_pkg::day_t day, gda_pkg::year_t year,
                             gda_pkg::count_t count, bit typed,
                             gda_pkg::gda_result_t want);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, count, year, day, month};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_dates.push_back(typed ? want : shifted_date(op, month, day, year, count));
    endtask

    task automatic send_random_date();
        gda_pkg::gda_op_t op;
        gda_pkg::month_t  month;
        gda_pkg::day_t    day;
        gda_pkg::year_t   year;
        gda_pkg::count_t  count;
        int               y;
        op = gda_pkg::gda_op_t'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       count = gda_pkg::count_t'($urandom);
            1:       count = gda_pkg::count_t'($urandom_range(0, 4095));
            default: count = gda_pkg::count_t'($urandom_range(0, 400));
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: any field pattern, mostly invalid dates
            month = gda_pkg::month_t'($urandom);
            day   = gda_pkg::day_t'($urandom);
            year  = gda_pkg::year_t'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       y = int'($urandom_range(FIRST_YEAR, FIRST_YEAR + 12));
                1:       y = int'($urandom_range(FINAL_YEAR - 12, FINAL_YEAR));
                default: y = int'($urandom_range(FIRST_YEAR, FINAL_YEAR));
            endcase
            year  = gda_pkg::year_t'(y);
            month = gda_pkg::month_t'($urandom_range(1, 12));
            if ($urandom_range(0, 3) == 0)
                day = gda_pkg::day_t'(days_in_month(int'(month), y) - $urandom_range(0, 1));
            else
                day = gda_pkg::day_t'($urandom_range(1, days_in_month(int'(month), y)));
        end
        send_date(op, month, day, year, count, 1'b0, '0);
    endtask

    task automatic drain_dates();
        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        gda_pkg::gda_result_t got;
        gda_pkg::gda_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.month   = m_axis_tdata[3:0];
            got.day     = m_axis_tdata[8:4];
            got.year    = m_axis_tdata[20:9];
            got.doy     = m_axis_tdata[29:21];
            got.weekday = m_axis_tdata[32:30];
            got.leap    = m_axis_tdata[33];
            got.error   = m_axis_tuser[0];
            if (pending_dates.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual %h/%h",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("out_month",   int'(want.month),   int'(got.month));
                check_field("out_day",     int'(want.day),     int'(got.day));
                check_field("out_year",    int'(want.year),    int'(got.year));
                check_field("day_of_year", int'(want.doy),     int'(got.doy));
                check_field("weekday",     int'(want.weekday), int'(got.weekday));
                check_field("leap",        int'(want.leap),    int'(got.leap));
                check_field("error",       int'(want.error),   int'(got.error));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 34;
        rx_idle_pct = 85;
        foreach (directed_dates[i])
            send_date(directed_dates[i].op, directed_dates[i].month, directed_dates[i].day,
                      directed_dates[i].year, directed_dates[i].count,
                      directed_dates[i].typed, directed_dates[i].want);
        drain_dates();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 34 : 0;
            repeat (PHASE_ITEMS) send_random_date();
            drain_dates();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
